### hdl/tie_pkg.sv
package tie_pkg;

   localparam int NUM_REGS          = 12;
   localparam int LAST_REG          = 11;
   localparam int MEM_WORDS_DEFAULT = 4096;

   typedef enum logic [4:0] {
      OP_LDR  = 5'd0,
      OP_STR  = 5'd1,
      OP_ADD  = 5'd2,
      OP_SUB  = 5'd3,
      OP_MOV  = 5'd4,
      OP_CMP  = 5'd5,
      OP_B    = 5'd6,
      OP_BEQ  = 5'd7,
      OP_BNE  = 5'd8,
      OP_BGT  = 5'd9,
      OP_BLT  = 5'd10,
      OP_AND  = 5'd11,
      OP_ORR  = 5'd12,
      OP_EOR  = 5'd13,
      OP_MVN  = 5'd14,
      OP_LSL  = 5'd15,
      OP_LSR  = 5'd16,
      OP_HALT = 5'd17,
      OP_OUT  = 5'd18,
      OP_DUMP = 5'd19
   } op_type;

   typedef enum logic [1:0] {
      FAULT_NONE   = 2'd0,
      FAULT_REG    = 2'd1,
      FAULT_OPCODE = 2'd2
   } fault_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [3:0]  dest_reg;
      logic [3:0]  src_reg;
      logic [63:0] operand_value;
      logic        operand_is_immediate;
      logic [11:0] memory_address;
      logic [15:0] branch_target;
   } req_type;

   typedef struct packed {
      logic [15:0] next_ip;
      logic        halted;
      logic        print_valid;
      logic [3:0]  print_reg;
      logic [63:0] print_value;
      logic [1:0]  fault;
   } rsp_type;

endpackage

### hdl/teaching_isa_execute_unit.sv
// Requests are held in the stage registers, then in the registered response. Throughput:
// one instruction per cycle unless stalled; operands are read from the register file and
// data memory at acceptance, and the single write port of each is written at execution.
// Reset clears the pipeline valids, the flags, the halt flag, the instruction pointer and
// the register valid bits (so registers read as zero); data memory is not cleared.
module teaching_isa_execute_unit
   import tie_pkg::*;
#(
   parameter int MEM_WORDS = MEM_WORDS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int MemAw = $clog2(MEM_WORDS);

   // storage
   logic [63:0] reg_file_mem [NUM_REGS];
   logic [63:0] data_mem     [MEM_WORDS];
   logic [NUM_REGS-1:0] rf_valid_ff, rf_valid_in;

   // handshake
   logic req_fire, s1_fire;
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // execute stage inputs
   req_type     s1_req_ff;
   logic [3:0]  rfa_addr_ff, rfb_addr_ff;
   logic [63:0] rfa_data_ff, rfb_data_ff, mem_rd_ff;

   // read addresses at acceptance
   logic [3:0]       rfa_addr_in, rfb_addr_in;
   logic [16:0]      req_addr_wide, s1_addr_wide;
   logic [MemAw-1:0] mem_idx_in, s1_mem_idx;

   // last write of each store, for reads taken at the same edge
   logic             rf_fwd_valid_ff;
   logic [3:0]       rf_fwd_addr_ff;
   logic [63:0]      rf_fwd_data_ff;
   logic             st_fwd_valid_ff;
   logic [MemAw-1:0] st_fwd_addr_ff;
   logic [63:0]      st_fwd_data_ff;

   // architectural state
   logic        eq_ff, ne_ff, gt_ff, lt_ff, halt_ff;
   logic        eq_in, ne_in, gt_in, lt_in, halt_in;
   logic [15:0] ip_ff, ip_in;

   // execute logic
   logic        use_rd, use_rn, use_op2;
   fault_type   fault;
   logic        exec;
   logic        addr_ok;
   logic [63:0] opa, opb_reg, opb, load_data, wr_data;
   logic        rf_we, mem_we;
   logic [15:0] next_ip;
   logic        print_valid;

   assign req_fire  = req_valid & ~req_stall;
   assign s1_fire   = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = s1_valid_ff & ~s1_fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Port A reads the register that STR stores or OUT prints, else Rn.
   always_comb begin
      if (req_data.kind == OP_STR || req_data.kind == OP_OUT) begin
         rfa_addr_in = req_data.dest_reg;
      end else begin
         rfa_addr_in = req_data.src_reg;
      end
      rfb_addr_in   = req_data.operand_value[3:0];
      req_addr_wide = 17'(req_data.memory_address);
      mem_idx_in    = req_addr_wide[MemAw-1:0];
      s1_addr_wide  = 17'(s1_req_ff.memory_address);
      s1_mem_idx    = s1_addr_wide[MemAw-1:0];
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff   <= req_data;
         rfa_addr_ff <= rfa_addr_in;
         rfb_addr_ff <= rfb_addr_in;
         if (rfa_addr_in <= 4'(LAST_REG) && rf_valid_ff[rfa_addr_in]) begin
            rfa_data_ff <= reg_file_mem[rfa_addr_in];
         end else begin
            rfa_data_ff <= '0;
         end
         if (req_data.operand_value <= 64'(LAST_REG) && rf_valid_ff[rfb_addr_in]) begin
            rfb_data_ff <= reg_file_mem[rfb_addr_in];
         end else begin
            rfb_data_ff <= '0;
         end
         mem_rd_ff <= data_mem[mem_idx_in];
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         reg_file_mem[s1_req_ff.dest_reg] <= wr_data;
      end
      if (mem_we) begin
         data_mem[s1_mem_idx] <= opa;
      end
   end

   // Take the newest write when it hits the entry that was read.
   always_comb begin
      if (rf_fwd_valid_ff && rf_fwd_addr_ff == rfa_addr_ff) begin
         opa = rf_fwd_data_ff;
      end else begin
         opa = rfa_data_ff;
      end
      if (rf_fwd_valid_ff && rf_fwd_addr_ff == rfb_addr_ff) begin
         opb_reg = rf_fwd_data_ff;
      end else begin
         opb_reg = rfb_data_ff;
      end
      opb     = s1_req_ff.operand_is_immediate ? s1_req_ff.operand_value : opb_reg;
      addr_ok = s1_addr_wide < 17'(MEM_WORDS);
      if (!addr_ok) begin
         load_data = '0;
      end else if (st_fwd_valid_ff && st_fwd_addr_ff == s1_mem_idx) begin
         load_data = st_fwd_data_ff;
      end else begin
         load_data = mem_rd_ff;
      end
   end

   always_comb begin
      use_rd  = 1'b0;
      use_rn  = 1'b0;
      use_op2 = 1'b0;
      case (s1_req_ff.kind)
         OP_LDR, OP_STR, OP_OUT: begin
            use_rd = 1'b1;
         end
         OP_ADD, OP_SUB, OP_AND, OP_ORR, OP_EOR, OP_LSL, OP_LSR: begin
            use_rd  = 1'b1;
            use_rn  = 1'b1;
            use_op2 = 1'b1;
         end
         OP_MOV, OP_MVN: begin
            use_rd  = 1'b1;
            use_op2 = 1'b1;
         end
         OP_CMP: begin
            use_rn  = 1'b1;
            use_op2 = 1'b1;
         end
         default: begin
         end
      endcase

      if (s1_req_ff.kind > OP_DUMP) begin
         fault = FAULT_OPCODE;
      end else if ((use_rd && s1_req_ff.dest_reg > 4'(LAST_REG)) ||
                   (use_rn && s1_req_ff.src_reg > 4'(LAST_REG)) ||
                   (use_op2 && !s1_req_ff.operand_is_immediate &&
                    s1_req_ff.operand_value > 64'(LAST_REG))) begin
         fault = FAULT_REG;
      end else begin
         fault = FAULT_NONE;
      end
   end

   always_comb begin
      exec        = s1_fire & ~halt_ff & (fault == FAULT_NONE);
      eq_in       = eq_ff;
      ne_in       = ne_ff;
      gt_in       = gt_ff;
      lt_in       = lt_ff;
      halt_in     = halt_ff;
      next_ip     = ip_ff + 16'd1;
      rf_we       = 1'b0;
      mem_we      = 1'b0;
      wr_data     = opb;
      print_valid = 1'b0;
      if (exec) begin
         case (s1_req_ff.kind)
            OP_LDR: begin
               rf_we   = 1'b1;
               wr_data = load_data;
            end
            OP_STR: begin
               mem_we = addr_ok;
            end
            OP_ADD: begin
               rf_we   = 1'b1;
               wr_data = opa + opb;
            end
            OP_SUB: begin
               rf_we   = 1'b1;
               wr_data = opa - opb;
            end
            OP_MOV: begin
               rf_we   = 1'b1;
               wr_data = opb;
            end
            OP_CMP: begin
               eq_in = opa == opb;
               ne_in = opa != opb;
               gt_in = opa > opb;
               lt_in = opa < opb;
            end
            OP_B: begin
               next_ip = s1_req_ff.branch_target;
            end
            // a taken conditional branch consumes its flag
            OP_BEQ: begin
               if (eq_ff) begin
                  eq_in   = 1'b0;
                  next_ip = s1_req_ff.branch_target;
               end
            end
            OP_BNE: begin
               if (ne_ff) begin
                  ne_in   = 1'b0;
                  next_ip = s1_req_ff.branch_target;
               end
            end
            OP_BGT: begin
               if (gt_ff) begin
                  gt_in   = 1'b0;
                  next_ip = s1_req_ff.branch_target;
               end
            end
            OP_BLT: begin
               if (lt_ff) begin
                  lt_in   = 1'b0;
                  next_ip = s1_req_ff.branch_target;
               end
            end
            OP_AND: begin
               rf_we   = 1'b1;
               wr_data = opa & opb;
            end
            OP_ORR: begin
               rf_we   = 1'b1;
               wr_data = opa | opb;
            end
            OP_EOR: begin
               rf_we   = 1'b1;
               wr_data = opa ^ opb;
            end
            OP_MVN: begin
               rf_we   = 1'b1;
               wr_data = ~opb;
            end
            OP_LSL: begin
               rf_we   = 1'b1;
               wr_data = (opb < 64'd64) ? (opa << opb[5:0]) : '0;
            end
            OP_LSR: begin
               rf_we   = 1'b1;
               wr_data = (opb < 64'd64) ? (opa >> opb[5:0]) : '0;
            end
            OP_HALT: begin
               halt_in = 1'b1;
            end
            OP_OUT: begin
               print_valid = 1'b1;
            end
            default: begin
            end
         endcase
      end

      // while halted the pointer holds
      ip_in = ip_ff;
      if (s1_fire && !halt_ff) begin
         ip_in = next_ip;
      end

      rf_valid_in = rf_valid_ff;
      if (rf_we) begin
         rf_valid_in[s1_req_ff.dest_reg] = 1'b1;
      end

      rsp_data_in.next_ip     = ip_in;
      rsp_data_in.halted      = halt_in;
      rsp_data_in.print_valid = print_valid;
      rsp_data_in.print_reg   = print_valid ? s1_req_ff.dest_reg : 4'd0;
      rsp_data_in.print_value = print_valid ? opa : 64'd0;
      rsp_data_in.fault       = halt_ff ? FAULT_NONE : fault;

      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (rf_we) begin
         rf_fwd_addr_ff <= s1_req_ff.dest_reg;
         rf_fwd_data_ff <= wr_data;
      end
      if (mem_we) begin
         st_fwd_addr_ff <= s1_mem_idx;
         st_fwd_data_ff <= opa;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         rf_valid_ff     <= '0;
         rf_fwd_valid_ff <= 1'b0;
         st_fwd_valid_ff <= 1'b0;
         eq_ff           <= 1'b0;
         ne_ff           <= 1'b0;
         gt_ff           <= 1'b0;
         lt_ff           <= 1'b0;
         halt_ff         <= 1'b0;
         ip_ff           <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rf_valid_ff  <= rf_valid_in;
         if (rf_we) begin
            rf_fwd_valid_ff <= 1'b1;
         end
         if (mem_we) begin
            st_fwd_valid_ff <= 1'b1;
         end
         eq_ff   <= eq_in;
         ne_ff   <= ne_in;
         gt_ff   <= gt_in;
         lt_ff   <= lt_in;
         halt_ff <= halt_in;
         ip_ff   <= ip_in;
      end
   end

endmodule
